// File: hdl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is high
`define TOF_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("tof assertion failed");

// clocked assertion that also holds across reset
`define TOF_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("tof assertion failed");

`endif

// File: hdl/tof_pkg.sv
// shared types and constants of the timed one-pole filter
package tof_pkg;

   localparam int MAX_STEPS = 16;
   localparam int STEP_W    = $clog2(MAX_STEPS + 1);
   // elapsed ticks at or below the gap limit shifted by 15 never exceed 16
   localparam int RAW_W     = 5;
   localparam int STEP_SHIFT = 15;
   localparam int DATA_W    = 32;
   localparam int COEF_W    = 31;
   localparam int OUT_W     = 17;
   localparam int ADDR_W    = 4;
   localparam int MUL_Y_W   = COEF_W + 2;
   localparam int PROD_W    = DATA_W + MUL_Y_W;

   localparam logic [DATA_W-1:0]        GAP_LIMIT = 32'h0008_0000;
   localparam logic signed [DATA_W-1:0] CLAMP_HI  = 32'sd32767;
   localparam logic signed [DATA_W-1:0] CLAMP_LO  = -32'sd32767;
   localparam logic [COEF_W-1:0]        Q31_ONE   = 31'h7FFF_FFFF;
   localparam logic [COEF_W-1:0]        RST_POLE  = 31'd2146134767;
   localparam logic [COEF_W-1:0]        RST_FEED  = 31'd2146809206;

   typedef enum logic [1:0] {
      REG_FILTER_MODE = 2'd0,
      REG_POLE_COEF   = 2'd1,
      REG_FEED_COEF   = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   // product taken in one step: input feed, input history, pole feedback
   typedef enum logic [1:0] {
      OP_FEED,
      OP_HIST,
      OP_POLE
   } op_type;

   typedef struct packed {
      logic              mode;
      logic [COEF_W-1:0] pole;
      logic [COEF_W-1:0] feed;
   } cfg_type;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_tag_type;

   typedef struct packed {
      logic              last_fire;
      logic [DATA_W-1:0] sum;
   } mac_res_type;

endpackage

// File: hdl/tof_csr.sv
// configuration registers behind the apb-style port
module tof_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [tof_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output tof_pkg::cfg_type            cfg
);

   tof_pkg::cfg_type       cfg_ff;
   tof_pkg::reg_index_type reg_index;
   logic                   wr_en;

   assign csr_pready = 1'b1;
   assign reg_index  = tof_pkg::reg_index_type'(csr_paddr[tof_pkg::ADDR_W-1:2]);
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign cfg        = cfg_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode <= 1'b0;
         cfg_ff.pole <= tof_pkg::RST_POLE;
         cfg_ff.feed <= tof_pkg::RST_FEED;
      end else if (wr_en) begin
         case (reg_index)
            tof_pkg::REG_FILTER_MODE: cfg_ff.mode <= csr_pwdata[0];
            tof_pkg::REG_POLE_COEF:   cfg_ff.pole <= csr_pwdata[tof_pkg::COEF_W-1:0];
            tof_pkg::REG_FEED_COEF:   cfg_ff.feed <= csr_pwdata[tof_pkg::COEF_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (reg_index)
         tof_pkg::REG_FILTER_MODE: csr_prdata = {31'd0, cfg_ff.mode};
         tof_pkg::REG_POLE_COEF:   csr_prdata = {1'b0, cfg_ff.pole};
         tof_pkg::REG_FEED_COEF:   csr_prdata = {1'b0, cfg_ff.feed};
         default:                  csr_prdata = '0;
      endcase
   end

endmodule

// File: hdl/tof_mac.sv
// shared multiply-high and accumulate unit, one product per cycle
module tof_mac (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tof_pkg::mac_tag_type                  tag,
   input  logic signed [tof_pkg::DATA_W-1:0]     op_x,
   input  logic signed [tof_pkg::MUL_Y_W-1:0]    op_y,
   output tof_pkg::mac_res_type                  res
);

   logic signed [tof_pkg::PROD_W-1:0] prod;
   logic [tof_pkg::DATA_W-1:0]        prod_hi_ff;
   logic [tof_pkg::DATA_W-1:0]        acc_ff;
   logic [tof_pkg::DATA_W-1:0]        acc_base;
   logic [tof_pkg::DATA_W-1:0]        sum;
   tof_pkg::mac_tag_type              tag_ff;

   // product, keep the floor of product / 2^32
   assign prod = op_x * op_y;

   always_ff @(posedge clock) begin
      prod_hi_ff <= prod[2*tof_pkg::DATA_W-1:tof_pkg::DATA_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag;
      end
   end

   // accumulate, first product of a step starts from zero
   assign acc_base = tag_ff.first ? '0 : acc_ff;
   assign sum      = acc_base + prod_hi_ff;

   always_ff @(posedge clock) begin
      if (tag_ff.valid) begin
         acc_ff <= sum;
      end
   end

   assign res.last_fire = tag_ff.valid & tag_ff.last;
   assign res.sum       = sum;

endmodule

// File: hdl/timed_one_pole_filter_core.sv
// top level of the timed one-pole filter: sequencer and filter state
//
// usage:
//  - req channel carries a timer reading and a signed sample per word; the
//    block takes one word at a time and drops req_ready until it is done
//  - the elapsed ticks since the last executed update, over 2^15, give
//    0..16 filter steps; a gap above 0x80000 ticks gives one step
//  - each step runs 3 products (high-pass) or 2 (low-pass) through one
//    shared 32x33 multiplier at one product per cycle; a word passes
//    through PREP, RUN, DRAIN and DONE before rsp_valid rises, and a
//    word with no step due goes from PREP straight to DONE
//  - req_ready returns in the cycle rsp_valid rises
//  - rsp channel holds one result word in an output register; the block
//    accepts the next req word while it waits and only stalls at the end
//    of that word if rsp_ready is still low
//  - reset clears filter history and last time, loads the default
//    coefficients and selects high-pass
//  - configuration must be written through the csr port while idle; the block does not enforce it
module timed_one_pole_filter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tof_pkg::DATA_W-1:0]         req_timer_reading,
   input  logic signed [tof_pkg::DATA_W-1:0]  req_sample_in,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [tof_pkg::OUT_W-1:0]   rsp_filtered_out,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tof_pkg::ADDR_W-1:0]         csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);

   tof_pkg::cfg_type                      cfg;
   tof_pkg::state_type                    state_ff, state_in;
   tof_pkg::op_type                       op_ff, op_in;
   tof_pkg::mac_tag_type                  tag;
   tof_pkg::mac_res_type                  res;

   logic [tof_pkg::DATA_W-1:0]            timer_ff;
   logic signed [tof_pkg::DATA_W-1:0]     sample_ff;
   logic [tof_pkg::DATA_W-1:0]            v_ff, v_in;
   logic [tof_pkg::STEP_W-1:0]            steps_left_ff;
   logic [tof_pkg::DATA_W-1:0]            prev_input_ff;
   logic [tof_pkg::DATA_W-1:0]            prev_output_ff;
   logic [tof_pkg::DATA_W-1:0]            last_time_ff;
   logic [tof_pkg::OUT_W-1:0]             result_ff;
   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [tof_pkg::OUT_W-1:0]             rsp_out_ff;

   logic [tof_pkg::DATA_W-1:0]            delta;
   logic [tof_pkg::RAW_W-1:0]             raw_steps;
   logic [tof_pkg::STEP_W-1:0]            steps;
   logic signed [tof_pkg::DATA_W-1:0]     clamped;
   logic                                  out_free;
   logic                                  accept;
   logic                                  prep_en;
   logic                                  run_en;
   logic                                  load_out;
   logic                                  last_op;
   logic signed [tof_pkg::DATA_W-1:0]     op_x;
   logic signed [tof_pkg::MUL_Y_W-1:0]    op_y;
   logic [tof_pkg::COEF_W-1:0]            lp_feed;

   tof_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   tof_mac u_mac (
      .clock (clock),
      .reset (reset),
      .tag   (tag),
      .op_x  (op_x),
      .op_y  (op_y),
      .res   (res)
   );

   // step count from elapsed time
   assign delta     = timer_ff - last_time_ff;
   assign raw_steps = (delta > tof_pkg::GAP_LIMIT) ? tof_pkg::RAW_W'(1)
                                                    : delta[tof_pkg::STEP_SHIFT +: tof_pkg::RAW_W];
   assign steps     = (raw_steps > tof_pkg::RAW_W'(tof_pkg::MAX_STEPS))
                         ? tof_pkg::STEP_W'(tof_pkg::MAX_STEPS)
                         : tof_pkg::STEP_W'(raw_steps);

   // clamp sample and scale by 2^16
   always_comb begin
      if (sample_ff < tof_pkg::CLAMP_LO) begin
         clamped = tof_pkg::CLAMP_LO;
      end else if (sample_ff > tof_pkg::CLAMP_HI) begin
         clamped = tof_pkg::CLAMP_HI;
      end else begin
         clamped = sample_ff;
      end
   end
   assign v_in = {clamped[15:0], 16'd0};

   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign last_op  = (op_ff == tof_pkg::OP_POLE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tof_pkg::ST_IDLE: begin
            if (req_valid) state_in = tof_pkg::ST_PREP;
         end
         tof_pkg::ST_PREP: begin
            state_in = (steps == '0) ? tof_pkg::ST_DONE : tof_pkg::ST_RUN;
         end
         tof_pkg::ST_RUN: begin
            if (last_op && steps_left_ff == tof_pkg::STEP_W'(1)) state_in = tof_pkg::ST_DRAIN;
         end
         tof_pkg::ST_DRAIN: state_in = tof_pkg::ST_DONE;
         tof_pkg::ST_DONE: begin
            if (out_free) state_in = tof_pkg::ST_IDLE;
         end
         default: state_in = tof_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      prep_en   = 1'b0;
      run_en    = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         tof_pkg::ST_IDLE: req_ready = 1'b1;
         tof_pkg::ST_PREP: prep_en   = 1'b1;
         tof_pkg::ST_RUN:  run_en    = 1'b1;
         tof_pkg::ST_DONE: load_out  = out_free;
         default: ;
      endcase
   end

   assign accept = req_valid & req_ready;

   // next product of the step
   always_comb begin
      case (op_ff)
         tof_pkg::OP_FEED: op_in = cfg.mode ? tof_pkg::OP_POLE : tof_pkg::OP_HIST;
         tof_pkg::OP_HIST: op_in = tof_pkg::OP_POLE;
         tof_pkg::OP_POLE: op_in = tof_pkg::OP_FEED;
         default:          op_in = tof_pkg::OP_FEED;
      endcase
   end

   // operand select for the shared multiplier
   assign lp_feed = tof_pkg::Q31_ONE - cfg.pole;
   always_comb begin
      case (op_ff)
         tof_pkg::OP_FEED: begin
            op_x = v_ff;
            op_y = cfg.mode ? {2'b00, lp_feed} : {2'b00, cfg.feed};
         end
         tof_pkg::OP_HIST: begin
            op_x = prev_input_ff;
            op_y = tof_pkg::MUL_Y_W'(0) - {2'b00, cfg.feed};
         end
         tof_pkg::OP_POLE: begin
            op_x = prev_output_ff;
            op_y = {2'b00, cfg.pole};
         end
         default: begin
            op_x = '0;
            op_y = '0;
         end
      endcase
   end

   assign tag.valid = run_en;
   assign tag.first = (op_ff == tof_pkg::OP_FEED);
   assign tag.last  = last_op;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tof_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
   assign rsp_valid_in = load_out | (rsp_valid_ff & ~rsp_ready);

   // step and product counters
   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff         <= tof_pkg::OP_FEED;
         steps_left_ff <= '0;
      end else if (prep_en) begin
         op_ff         <= tof_pkg::OP_FEED;
         steps_left_ff <= steps;
      end else if (run_en) begin
         op_ff <= op_in;
         if (last_op) steps_left_ff <= steps_left_ff - tof_pkg::STEP_W'(1);
      end
   end

   // filter history and time of last update
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_input_ff  <= '0;
         prev_output_ff <= '0;
         last_time_ff   <= '0;
      end else begin
         if (prep_en && steps != '0) last_time_ff <= timer_ff;
         if (res.last_fire) begin
            prev_input_ff  <= v_ff;
            prev_output_ff <= {res.sum[tof_pkg::DATA_W-2:0], 1'b0};
         end
      end
   end

   // word capture and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         timer_ff  <= req_timer_reading;
         sample_ff <= req_sample_in;
      end
      if (prep_en) begin
         v_ff <= v_in;
         if (steps == '0) begin
            result_ff <= {prev_output_ff[tof_pkg::DATA_W-1],
                          prev_output_ff[tof_pkg::DATA_W-1:16]};
         end
      end
      if (res.last_fire) result_ff <= res.sum[tof_pkg::DATA_W-1:15];
      if (load_out) rsp_out_ff <= result_ff;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_filtered_out = rsp_out_ff;

endmodule

// File: hdl/tof_checker.sv
// port-level checker for the timed one-pole filter, bound to the top level
`include "assert_macros.svh"

module tof_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic signed [tof_pkg::OUT_W-1:0]   rsp_filtered_out,
   input logic                               csr_pready
);

   // after reset the block is empty and ready for a word
   `TOF_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid && req_ready))

   // one word at a time: ready drops right after an accept
   `TOF_ASSERT(a_one_at_a_time, clock, reset, (req_valid && req_ready) |=> !req_ready)

   // a stalled result holds
   `TOF_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_filtered_out)))

   // config port never inserts wait states
   `TOF_ASSERT_ALWAYS(a_pready_high, clock, csr_pready)

endmodule

bind timed_one_pole_filter_core tof_checker u_tof_checker (.*);
